// ----- hw/rtl/sil_pkg.sv -----
`timescale 1ns / 1ps

package sil_pkg;

	// register file
	localparam int unsigned PADDR_W       = 3;
	localparam int unsigned PDATA_W       = 32;
	localparam logic        REG_LOAD_BASE = 1'b0;
	localparam logic        REG_MODULUS   = 1'b1;

	// reset values of the configuration registers
	localparam logic [31:0] LOAD_BASE_RST = 32'h0008_0000;
	localparam logic [30:0] MODULUS_RST   = 31'd856039;

	// header layout
	localparam int unsigned HEADER_DIGITS_DEF = 32;
	localparam logic [31:0] ASCII_ZERO        = 32'd48;

	// command codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_SIZE = 4'b0010,
		PH_SUM  = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

endpackage

// ----- hw/rtl/serial_image_loader.sv -----
`timescale 1ns / 1ps

// a result beat is registered and shown in the cycle after its input beat is accepted
// throughput: one beat per cycle while out_ready does not stall it; the result register is the only stage, and
// in_ready stays high while that register is empty or being drained
// reset (arst_n low, asynchronous): loader idle, result register empty,
// load_base = 0x80000, modulus = 856039
module serial_image_loader #(
	parameter int unsigned HEADER_DIGITS = sil_pkg::HEADER_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// apb configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sil_pkg::PADDR_W-1:0] paddr,
	input  logic [sil_pkg::PDATA_W-1:0] pwdata,
	output logic [sil_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [7:0]                  rx_byte,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        mem_write,
	output logic [31:0]                 write_address,
	output logic [7:0]                  write_data,
	output logic                        finished,
	output logic                        checksum_ok
);
	import sil_pkg::*;

	// digit counter just wide enough to reach the last header digit
	localparam int unsigned DCW = (HEADER_DIGITS > 1) ? $clog2(HEADER_DIGITS) : 1;
	localparam logic [DCW-1:0] LAST_DIGIT = DCW'(HEADER_DIGITS - 1);

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [31:0] load_base_q;
	logic [30:0] modulus_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// only paddr[2] selects the register, the byte offset bits are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_base_q <= LOAD_BASE_RST;
			modulus_q   <= MODULUS_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_LOAD_BASE: load_base_q <= pwdata;
				REG_MODULUS:   modulus_q   <= pwdata[30:0];
				default:       load_base_q <= load_base_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LOAD_BASE: prdata = load_base_q;
			REG_MODULUS:   prdata = {1'b0, modulus_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// loader state
	// ---------------------------------------------------------------
	phase_t      phase_q;
	logic [DCW-1:0] digit_cnt_q;
	logic [31:0] hdr_acc_q;
	logic [31:0] size_q;
	logic [31:0] exp_sum_q;
	logic [30:0] byte_idx_q;
	logic [30:0] run_sum_q;

	// result register
	logic        out_valid_q;
	logic        mem_write_q;
	logic [31:0] wr_addr_q;
	logic [7:0]  wr_data_q;
	logic        finished_q;
	logic        cks_ok_q;

	logic in_acc;

	// the result register frees up in the same cycle it is drained
	assign in_ready = ~out_valid_q | out_ready;
	assign in_acc   = in_valid & in_ready;

	// ---------------------------------------------------------------
	// next-state logic for one beat
	// ---------------------------------------------------------------
	logic [31:0] acc_next;
	logic        last_digit;
	logic [30:0] sum_wrapped;
	logic [30:0] sum_next;
	logic [30:0] idx_next;

	phase_t      phase_d;
	logic [DCW-1:0] digit_cnt_d;
	logic [31:0] hdr_acc_d;
	logic [31:0] size_d;
	logic [31:0] exp_sum_d;
	logic [30:0] byte_idx_d;
	logic [30:0] run_sum_d;
	logic        mem_write_d;
	logic [31:0] wr_addr_d;
	logic [7:0]  wr_data_d;
	logic        finished_d;
	logic        cks_ok_d;

	// acc * 10 + (byte - '0'), wrapping at 32 bits
	assign acc_next   = (hdr_acc_q << 3) + (hdr_acc_q << 1) + {24'd0, rx_byte} - ASCII_ZERO;
	assign last_digit = (digit_cnt_q == LAST_DIGIT);

	// running sum with one conditional subtract of the modulus
	assign sum_wrapped = run_sum_q + {23'd0, rx_byte};
	assign sum_next    = (sum_wrapped >= modulus_q) ? (sum_wrapped - modulus_q) : sum_wrapped;
	assign idx_next    = byte_idx_q + 31'd1;

	always_comb begin
		phase_d     = phase_q;
		digit_cnt_d = digit_cnt_q;
		hdr_acc_d   = hdr_acc_q;
		size_d      = size_q;
		exp_sum_d   = exp_sum_q;
		byte_idx_d  = byte_idx_q;
		run_sum_d   = run_sum_q;
		mem_write_d = 1'b0;
		wr_addr_d   = '0;
		wr_data_d   = '0;
		finished_d  = 1'b0;
		cks_ok_d    = 1'b0;

		if (opcode == OP_START) begin
			// abandon whatever was in flight and wait for the size digits
			phase_d     = PH_SIZE;
			digit_cnt_d = '0;
			hdr_acc_d   = '0;
		end else begin
			case (phase_q)
				PH_SIZE, PH_SUM: begin
					hdr_acc_d   = acc_next;
					digit_cnt_d = digit_cnt_q + DCW'(1);
					if (last_digit) begin
						digit_cnt_d = '0;
						hdr_acc_d   = '0;
						if (phase_q == PH_SIZE) begin
							size_d  = acc_next;
							phase_d = PH_SUM;
						end else begin
							exp_sum_d  = acc_next;
							byte_idx_d = '0;
							run_sum_d  = '0;
							// size read as signed: zero or negative means no payload
							if (size_q == 32'd0 || size_q[31]) begin
								finished_d = 1'b1;
								cks_ok_d   = (acc_next == 32'd0);
								phase_d    = PH_IDLE;
							end else begin
								phase_d = PH_DATA;
							end
						end
					end
				end
				PH_DATA: begin
					mem_write_d = 1'b1;
					wr_addr_d   = load_base_q + {1'b0, byte_idx_q};
					wr_data_d   = rx_byte;
					run_sum_d   = sum_next;
					byte_idx_d  = idx_next;
					if ({1'b0, idx_next} == size_q) begin
						finished_d = 1'b1;
						cks_ok_d   = ({1'b0, sum_next} == exp_sum_q);
						phase_d    = PH_IDLE;
					end
				end
				default: begin
					// a byte while idle is dropped, the result is all zero
					phase_d = phase_q;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// state and result registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			digit_cnt_q <= '0;
			hdr_acc_q   <= '0;
			size_q      <= '0;
			exp_sum_q   <= '0;
			byte_idx_q  <= '0;
			run_sum_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q     <= phase_d;
				digit_cnt_q <= digit_cnt_d;
				hdr_acc_q   <= hdr_acc_d;
				size_q      <= size_d;
				exp_sum_q   <= exp_sum_d;
				byte_idx_q  <= byte_idx_d;
				run_sum_q   <= run_sum_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with every accepted beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem_write_q <= mem_write_d;
			wr_addr_q   <= wr_addr_d;
			wr_data_q   <= wr_data_d;
			finished_q  <= finished_d;
			cks_ok_q    <= cks_ok_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign mem_write     = mem_write_q;
	assign write_address = wr_addr_q;
	assign write_data    = wr_data_q;
	assign finished      = finished_q;
	assign checksum_ok   = cks_ok_q;

endmodule

// ----- hw/rtl/sil_checker.sv -----
`timescale 1ns / 1ps

module sil_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        mem_write,
	input logic [31:0] write_address,
	input logic [7:0]  write_data,
	input logic        finished,
	input logic        checksum_ok
);

	// an accepted beat always shows up as a result next cycle
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("accepted beat gave no result");

	// the input side never stalls while the result register is free
	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("in_ready low with room for a result");

	// a verdict only comes with the end of a transfer
	a_verdict_with_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && checksum_ok) |-> finished)
		else $error("checksum_ok without finished");

	// non-write results carry a zero address and data
	a_idle_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !mem_write) |-> (write_address == 32'd0 && write_data == 8'd0))
		else $error("write fields set on a non-write result");

	// a stalled result holds its address, data and finished flag
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(write_address)
			&& $stable(write_data) && $stable(finished)))
		else $error("stalled result changed");

endmodule

bind serial_image_loader sil_port_props u_sil_port_props (.*);
